// ===== src/bspline_point_evaluator_core_assert.svh =====
// Assertion macros used by the B-spline evaluator sequencer RTL.
// No dependencies; include by bare file name after the module ports.
`ifndef BSPLINE_POINT_EVALUATOR_CORE_ASSERT_SVH
`define BSPLINE_POINT_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpe: implication check failed");

// Next-cycle implication, disabled during reset.
`define BPE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpe: next-cycle check failed");

`endif

// ===== src/bpe_pkg.sv =====
// Shared types, constants and knot helpers of the B-spline point evaluator.
// No dependencies; the RTL and testbench files refer to it by scoped names.
package bpe_pkg;

   localparam int MAX_POINTS = 64;
   localparam int MAX_ORDER  = 8;

   localparam int COORD_W  = 32;
   localparam int ORDER_W  = 4;
   localparam int COUNT_W  = 7;
   localparam int PARAM_W  = 17;
   localparam int INDEX_W  = 6;
   localparam int FRAC_W   = 16;
   localparam int ONE_Q16  = 65536;
   localparam int BASIS_LIM = 1 << 20;

   localparam int PT_AW    = $clog2(MAX_POINTS);
   localparam int KNOT_LEN = MAX_POINTS + MAX_ORDER + 1;
   localparam int BIDX_W   = $clog2(KNOT_LEN);
   localparam int KNOT_W   = COUNT_W + 1;
   localparam int DIFF_W   = KNOT_W + 1;
   localparam int BASIS_W  = 22;
   localparam int POS_W    = PARAM_W + COUNT_W + 1;
   localparam int PROD_W   = POS_W + BASIS_W;
   localparam int DIVIDEND_W = PROD_W - FRAC_W;
   localparam int DIVISOR_W  = DIFF_W;
   localparam int TERM_W   = DIVIDEND_W + 1;
   localparam int SUMP_W   = COORD_W + BASIS_W;
   localparam int ACC_W    = SUMP_W + PT_AW;
   localparam int DIV_CW   = $clog2(DIVIDEND_W + 1);

   localparam int CSR_DW   = 32;
   localparam int REG_NUM  = 2;
   localparam int CSR_AW   = $clog2(REG_NUM * 4);

   localparam logic [CSR_AW-3:0] REG_ORDER = 1'b0;
   localparam logic [CSR_AW-3:0] REG_COUNT = 1'b1;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EVAL  = 1'b1
   } bpe_cmd_type;

   typedef struct packed {
      bpe_cmd_type               command;
      logic [INDEX_W-1:0]        point_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [PARAM_W-1:0]        curve_param;
   } bpe_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
   } bpe_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } bpe_point_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [COUNT_W-1:0] count;
   } bpe_cfg_type;

   typedef struct packed {
      logic                      pt_we;
      logic [PT_AW-1:0]          pt_waddr;
      bpe_point_type             pt_wdata;
      logic                      pt_re;
      logic [PT_AW-1:0]          pt_raddr;
      logic                      bs_we;
      logic [BIDX_W-1:0]         bs_waddr;
      logic signed [BASIS_W-1:0] bs_wdata;
      logic                      bs_re;
      logic [BIDX_W-1:0]         bs_raddr;
   } bpe_mem_ctl_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } bpe_div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } bpe_div_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_LVL_RD0,
      S_LVL_WAIT0,
      S_RD,
      S_WAIT,
      S_TERM,
      S_DSTART,
      S_DWAIT,
      S_WRITE,
      S_SUM_RD,
      S_SUM_MUL,
      S_SUM_ACC,
      S_DONE
   } bpe_state_type;

   // Integer knot: zeros for the first r slots, then i-r+1, then the end knot n-r+2.
   function automatic logic signed [KNOT_W-1:0] knot_at(
      input logic [BIDX_W-1:0]  idx,
      input logic [ORDER_W-1:0] r,
      input logic [COUNT_W-1:0] n);
      logic signed [KNOT_W+1:0] iv;
      logic signed [KNOT_W+1:0] rv;
      logic signed [KNOT_W+1:0] nv;
      logic signed [KNOT_W+1:0] v;
      iv = $signed({{(KNOT_W + 2 - BIDX_W){1'b0}}, idx});
      rv = $signed({{(KNOT_W + 2 - ORDER_W){1'b0}}, r});
      nv = $signed({{(KNOT_W + 2 - COUNT_W){1'b0}}, n});
      if (iv < rv) begin
         v = '0;
      end else if (iv < nv) begin
         v = iv - rv + 1;
      end else begin
         v = nv - rv + 2;
      end
      return v[KNOT_W-1:0];
   endfunction

   // Knot in the parameter's fixed-point position format.
   function automatic logic signed [POS_W-1:0] knot_pos(input logic signed [KNOT_W-1:0] kn);
      return {kn[KNOT_W-1], kn, {FRAC_W{1'b0}}};
   endfunction

endpackage

// ===== src/bpe_mem.sv =====
// Control point store and basis scratch memory, both with registered reads.
// Depends on bpe_pkg for widths and the memory control struct.
module bpe_mem (
   input  logic                              clock,
   input  bpe_pkg::bpe_mem_ctl_type          ctl,
   output bpe_pkg::bpe_point_type            pt_rdata,
   output logic signed [bpe_pkg::BASIS_W-1:0] bs_rdata
);

   bpe_pkg::bpe_point_type            pt_mem [bpe_pkg::MAX_POINTS];
   logic signed [bpe_pkg::BASIS_W-1:0] bs_mem [bpe_pkg::KNOT_LEN];

   bpe_pkg::bpe_point_type            pt_rdata_ff;
   logic signed [bpe_pkg::BASIS_W-1:0] bs_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.pt_we) begin
         pt_mem[ctl.pt_waddr] <= ctl.pt_wdata;
      end
      if (ctl.pt_re) begin
         pt_rdata_ff <= pt_mem[ctl.pt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.bs_we) begin
         bs_mem[ctl.bs_waddr] <= ctl.bs_wdata;
      end
      if (ctl.bs_re) begin
         bs_rdata_ff <= bs_mem[ctl.bs_raddr];
      end
   end

   assign pt_rdata = pt_rdata_ff;
   assign bs_rdata = bs_rdata_ff;

endmodule

// ===== src/bpe_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on bpe_pkg for widths and the request and response structs.
module bpe_div (
   input  logic                     clock,
   input  logic                     reset,
   input  bpe_pkg::bpe_div_req_type req,
   output bpe_pkg::bpe_div_rsp_type rsp
);

   logic [bpe_pkg::DIVISOR_W:0]    rem_ff, rem_in;
   logic [bpe_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [bpe_pkg::DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [bpe_pkg::DIV_CW-1:0]     cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [bpe_pkg::DIVISOR_W:0] rem_sh;
   logic                        fits;

   always_comb begin
      rem_sh = {rem_ff[bpe_pkg::DIVISOR_W-1:0], quo_ff[bpe_pkg::DIVIDEND_W-1]};
      fits   = rem_sh >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = bpe_pkg::DIV_CW'(bpe_pkg::DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, dsr_ff} : rem_sh;
         quo_in = {quo_ff[bpe_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bpe_pkg::DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== src/bpe_seq.sv =====
// Evaluation sequencer: point writes, knot logic, in-place Cox-de Boor update, weighted sum.
// Depends on bpe_pkg; drives bpe_mem and bpe_div through their structs.
module bpe_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bpe_pkg::bpe_req_type               req_data,
   input  bpe_pkg::bpe_cfg_type               cfg,
   output logic                               res_valid,
   input  logic                               res_ready,
   output bpe_pkg::bpe_rsp_type               res_data,
   output bpe_pkg::bpe_mem_ctl_type           mem_ctl,
   input  bpe_pkg::bpe_point_type             pt_rdata,
   input  logic signed [bpe_pkg::BASIS_W-1:0] bs_rdata,
   output bpe_pkg::bpe_div_req_type           div_req,
   input  bpe_pkg::bpe_div_rsp_type           div_rsp
);

   localparam int BSUM_W = bpe_pkg::TERM_W + 1;
   localparam logic signed [BSUM_W-1:0] LIM_HI = BSUM_W'(bpe_pkg::BASIS_LIM);
   localparam logic signed [BSUM_W-1:0] LIM_LO = -LIM_HI;

   bpe_pkg::bpe_state_type state_ff, state_in;

   logic [bpe_pkg::ORDER_W-1:0]        r_ff, r_in;
   logic [bpe_pkg::COUNT_W-1:0]        n_ff, n_in;
   logic signed [bpe_pkg::POS_W-1:0]   t_ff, t_in;
   logic                               closed_ff, closed_in;
   logic [bpe_pkg::BIDX_W-1:0]         i_ff, i_in;
   logic [bpe_pkg::ORDER_W-1:0]        k_ff, k_in;
   logic                               side_ff, side_in;
   logic signed [bpe_pkg::BASIS_W-1:0] b_cur_ff, b_cur_in;
   logic signed [bpe_pkg::BASIS_W-1:0] b_next_ff, b_next_in;
   logic signed [bpe_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                               dneg_ff, dneg_in;
   logic [bpe_pkg::DIVISOR_W-1:0]      dmag_ff, dmag_in;
   logic signed [bpe_pkg::TERM_W-1:0]  term_l_ff, term_l_in;
   logic signed [bpe_pkg::TERM_W-1:0]  term_r_ff, term_r_in;
   logic signed [bpe_pkg::SUMP_W-1:0]  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [bpe_pkg::ACC_W-1:0]   ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;

   // Effective configuration and scaled parameter at accept.
   logic [bpe_pkg::ORDER_W-1:0]             r_eff;
   logic [bpe_pkg::COUNT_W-1:0]             n_eff;
   logic [bpe_pkg::COUNT_W-1:0]             nm1;
   logic [bpe_pkg::PARAM_W-1:0]             t_clamp;
   logic [bpe_pkg::PARAM_W+bpe_pkg::COUNT_W-1:0] t_prod;
   logic [bpe_pkg::PARAM_W+bpe_pkg::COUNT_W-1:0] last_pos;

   // Knot and support logic for the current entry.
   logic [bpe_pkg::BIDX_W-1:0]         idx_k, idx_km1, idx_1, last_idx;
   logic signed [bpe_pkg::KNOT_W-1:0]  kn_i, kn_ik, kn_ikm1, kn_i1;
   logic signed [bpe_pkg::POS_W-1:0]   lo, hi, num_s;
   logic signed [bpe_pkg::DIFF_W-1:0]  d_l, d_r, d_s;
   logic signed [bpe_pkg::BASIS_W-1:0] b_s;
   logic                               in_span;
   logic [bpe_pkg::PROD_W-1:0]         prod_mag;
   logic signed [bpe_pkg::TERM_W-1:0]  q_ext, term_q;
   logic signed [BSUM_W-1:0]           bsum;
   logic signed [bpe_pkg::BASIS_W-1:0] basis_new;
   logic                               accept;

   function automatic logic signed [bpe_pkg::COORD_W-1:0] sat_out(
      input logic signed [bpe_pkg::ACC_W-1:0] acc);
      logic signed [bpe_pkg::ACC_W-1:0] adj;
      logic signed [bpe_pkg::ACC_W-1:0] q;
      adj = acc + (acc[bpe_pkg::ACC_W-1] ? bpe_pkg::ACC_W'(bpe_pkg::ONE_Q16 - 1)
                                         : bpe_pkg::ACC_W'(0));
      q = adj >>> bpe_pkg::FRAC_W;
      if (q > bpe_pkg::ACC_W'(32'sh7FFF_FFFF)) begin
         return 32'sh7FFF_FFFF;
      end else if (q < -bpe_pkg::ACC_W'(33'sh0_8000_0000)) begin
         return 32'sh8000_0000;
      end
      return q[bpe_pkg::COORD_W-1:0];
   endfunction

   function automatic logic signed [bpe_pkg::DIFF_W-1:0] DIFF_EXT(
      input logic signed [bpe_pkg::KNOT_W-1:0] kn);
      return {kn[bpe_pkg::KNOT_W-1], kn};
   endfunction

   always_comb begin
      if (cfg.order == '0) begin
         r_eff = bpe_pkg::ORDER_W'(1);
      end else if (cfg.order > bpe_pkg::ORDER_W'(bpe_pkg::MAX_ORDER)) begin
         r_eff = bpe_pkg::ORDER_W'(bpe_pkg::MAX_ORDER);
      end else begin
         r_eff = cfg.order;
      end
      if (cfg.count < bpe_pkg::COUNT_W'(2)) begin
         n_eff = bpe_pkg::COUNT_W'(2);
      end else if (cfg.count > bpe_pkg::COUNT_W'(bpe_pkg::MAX_POINTS)) begin
         n_eff = bpe_pkg::COUNT_W'(bpe_pkg::MAX_POINTS);
      end else begin
         n_eff = cfg.count;
      end
      nm1 = n_eff - 1'b1;
      t_clamp = (req_data.curve_param > bpe_pkg::PARAM_W'(bpe_pkg::ONE_Q16))
                ? bpe_pkg::PARAM_W'(bpe_pkg::ONE_Q16) : req_data.curve_param;
      t_prod   = t_clamp * nm1;
      last_pos = (bpe_pkg::PARAM_W + bpe_pkg::COUNT_W)'({nm1, {bpe_pkg::FRAC_W{1'b0}}});
   end

   always_comb begin
      idx_k    = i_ff + bpe_pkg::BIDX_W'(k_ff);
      idx_km1  = idx_k - 1'b1;
      idx_1    = i_ff + 1'b1;
      last_idx = bpe_pkg::BIDX_W'(n_ff) + bpe_pkg::BIDX_W'(r_ff) - bpe_pkg::BIDX_W'(k_ff);
      kn_i     = bpe_pkg::knot_at(i_ff, r_ff, n_ff);
      kn_ik    = bpe_pkg::knot_at(idx_k, r_ff, n_ff);
      kn_ikm1  = bpe_pkg::knot_at(idx_km1, r_ff, n_ff);
      kn_i1    = bpe_pkg::knot_at(idx_1, r_ff, n_ff);
      lo       = bpe_pkg::knot_pos(kn_i);
      hi       = bpe_pkg::knot_pos(kn_ik);
      in_span  = (t_ff >= lo) && (closed_ff ? (t_ff <= hi) : (t_ff < hi));
      d_l      = DIFF_EXT(kn_ikm1) - DIFF_EXT(kn_i);
      d_r      = DIFF_EXT(kn_ik) - DIFF_EXT(kn_i1);
      num_s    = side_ff ? (hi - t_ff) : (t_ff - lo);
      d_s      = side_ff ? d_r : d_l;
      b_s      = side_ff ? b_next_ff : b_cur_ff;
      prod_mag = prod_ff[bpe_pkg::PROD_W-1] ? bpe_pkg::PROD_W'(-prod_ff)
                                            : bpe_pkg::PROD_W'(prod_ff);
      q_ext    = $signed({1'b0, div_rsp.quotient});
      term_q   = (prod_ff[bpe_pkg::PROD_W-1] ^ dneg_ff) ? -q_ext : q_ext;
      bsum     = BSUM_W'(term_l_ff) + BSUM_W'(term_r_ff);
      if (bsum > LIM_HI) begin
         basis_new = bpe_pkg::BASIS_W'(LIM_HI);
      end else if (bsum < LIM_LO) begin
         basis_new = bpe_pkg::BASIS_W'(LIM_LO);
      end else begin
         basis_new = bsum[bpe_pkg::BASIS_W-1:0];
      end
   end

   // Next state and datapath registers.
   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      n_in      = n_ff;
      t_in      = t_ff;
      closed_in = closed_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      side_in   = side_ff;
      b_cur_in  = b_cur_ff;
      b_next_in = b_next_ff;
      prod_in   = prod_ff;
      dneg_in   = dneg_ff;
      dmag_in   = dmag_ff;
      term_l_in = term_l_ff;
      term_r_in = term_r_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      pz_in     = pz_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      az_in     = az_ff;
      accept    = 1'b0;
      req_stall = 1'b1;
      res_valid = 1'b0;

      mem_ctl          = '0;
      mem_ctl.pt_waddr = bpe_pkg::PT_AW'(req_data.point_index);
      mem_ctl.pt_wdata = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};
      mem_ctl.pt_raddr = bpe_pkg::PT_AW'(i_ff);
      mem_ctl.bs_waddr = i_ff;
      mem_ctl.bs_raddr = i_ff;
      div_req.start    = 1'b0;
      div_req.dividend = prod_mag[bpe_pkg::PROD_W-1:bpe_pkg::FRAC_W];
      div_req.divisor  = dmag_ff;

      case (state_ff)
         bpe_pkg::S_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
            if (req_valid) begin
               if (req_data.command == bpe_pkg::CMD_WRITE) begin
                  mem_ctl.pt_we = (int'(req_data.point_index) < bpe_pkg::MAX_POINTS);
               end else begin
                  r_in      = r_eff;
                  n_in      = n_eff;
                  t_in      = $signed({1'b0, t_prod});
                  closed_in = t_prod >= last_pos;
                  i_in      = '0;
                  k_in      = bpe_pkg::ORDER_W'(1);
                  ax_in     = '0;
                  ay_in     = '0;
                  az_in     = '0;
                  state_in  = bpe_pkg::S_INIT;
               end
            end
         end
         bpe_pkg::S_INIT: begin
            // Level one: indicator of the knot span.
            mem_ctl.bs_we    = 1'b1;
            mem_ctl.bs_wdata = in_span ? bpe_pkg::BASIS_W'(bpe_pkg::ONE_Q16) : '0;
            i_in = i_ff + 1'b1;
            if (i_ff == last_idx) begin
               i_in = '0;
               if (r_ff == bpe_pkg::ORDER_W'(1)) begin
                  state_in = bpe_pkg::S_SUM_RD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = bpe_pkg::S_LVL_RD0;
               end
            end
         end
         bpe_pkg::S_LVL_RD0: begin
            mem_ctl.bs_re = 1'b1;
            state_in      = bpe_pkg::S_LVL_WAIT0;
         end
         bpe_pkg::S_LVL_WAIT0: begin
            b_cur_in = bs_rdata;
            state_in = bpe_pkg::S_RD;
         end
         bpe_pkg::S_RD: begin
            // Read entry i+1 before entry i is overwritten; no overlap on one entry.
            mem_ctl.bs_re    = 1'b1;
            mem_ctl.bs_raddr = idx_1;
            state_in         = bpe_pkg::S_WAIT;
         end
         bpe_pkg::S_WAIT: begin
            b_next_in = bs_rdata;
            side_in   = 1'b0;
            state_in  = bpe_pkg::S_TERM;
         end
         bpe_pkg::S_TERM: begin
            if (!side_ff && !in_span) begin
               term_l_in = '0;
               term_r_in = '0;
               state_in  = bpe_pkg::S_WRITE;
            end else if (num_s == '0 || d_s == '0 || b_s == '0) begin
               if (side_ff) begin
                  term_r_in = '0;
                  state_in  = bpe_pkg::S_WRITE;
               end else begin
                  term_l_in = '0;
                  side_in   = 1'b1;
               end
            end else begin
               prod_in  = num_s * b_s;
               dneg_in  = d_s[bpe_pkg::DIFF_W-1];
               dmag_in  = d_s[bpe_pkg::DIFF_W-1] ? bpe_pkg::DIVISOR_W'(-d_s)
                                                 : bpe_pkg::DIVISOR_W'(d_s);
               state_in = bpe_pkg::S_DSTART;
            end
         end
         bpe_pkg::S_DSTART: begin
            div_req.start = 1'b1;
            state_in      = bpe_pkg::S_DWAIT;
         end
         bpe_pkg::S_DWAIT: begin
            if (div_rsp.done) begin
               if (side_ff) begin
                  term_r_in = term_q;
                  state_in  = bpe_pkg::S_WRITE;
               end else begin
                  term_l_in = term_q;
                  side_in   = 1'b1;
                  state_in  = bpe_pkg::S_TERM;
               end
            end
         end
         bpe_pkg::S_WRITE: begin
            mem_ctl.bs_we    = 1'b1;
            mem_ctl.bs_wdata = basis_new;
            b_cur_in         = b_next_ff;
            i_in             = i_ff + 1'b1;
            state_in         = bpe_pkg::S_RD;
            if (i_ff == last_idx) begin
               i_in = '0;
               if (k_ff == r_ff) begin
                  state_in = bpe_pkg::S_SUM_RD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = bpe_pkg::S_LVL_RD0;
               end
            end
         end
         bpe_pkg::S_SUM_RD: begin
            mem_ctl.pt_re = 1'b1;
            mem_ctl.bs_re = 1'b1;
            state_in      = bpe_pkg::S_SUM_MUL;
         end
         bpe_pkg::S_SUM_MUL: begin
            px_in    = pt_rdata.x * bs_rdata;
            py_in    = pt_rdata.y * bs_rdata;
            pz_in    = pt_rdata.z * bs_rdata;
            state_in = bpe_pkg::S_SUM_ACC;
         end
         bpe_pkg::S_SUM_ACC: begin
            ax_in = ax_ff + bpe_pkg::ACC_W'(px_ff);
            ay_in = ay_ff + bpe_pkg::ACC_W'(py_ff);
            az_in = az_ff + bpe_pkg::ACC_W'(pz_ff);
            i_in  = i_ff + 1'b1;
            state_in = bpe_pkg::S_SUM_RD;
            if (i_ff == bpe_pkg::BIDX_W'(n_ff - 1'b1)) begin
               state_in = bpe_pkg::S_DONE;
            end
         end
         bpe_pkg::S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = bpe_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bpe_pkg::S_IDLE;
         end
      endcase
   end

   assign res_data.out_x = sat_out(ax_ff);
   assign res_data.out_y = sat_out(ay_ff);
   assign res_data.out_z = sat_out(az_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpe_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      n_ff      <= n_in;
      t_ff      <= t_in;
      closed_ff <= closed_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      side_ff   <= side_in;
      b_cur_ff  <= b_cur_in;
      b_next_ff <= b_next_in;
      prod_ff   <= prod_in;
      dneg_ff   <= dneg_in;
      dmag_ff   <= dmag_in;
      term_l_ff <= term_l_in;
      term_r_ff <= term_r_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      pz_ff     <= pz_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      az_ff     <= az_in;
   end

`include "bspline_point_evaluator_core_assert.svh"

   `BPE_ASSERT_IMP(a_div_start_free, clock, reset, div_req.start, !div_rsp.busy)
   `BPE_ASSERT_IMP(a_idle_div_quiet, clock, reset, state_ff == bpe_pkg::S_IDLE, !div_rsp.busy)
   `BPE_ASSERT_NXT(a_eval_starts, clock, reset, accept && req_data.command == bpe_pkg::CMD_EVAL, state_ff == bpe_pkg::S_INIT)
   `BPE_ASSERT_IMP(a_basis_addr, clock, reset, mem_ctl.bs_we, mem_ctl.bs_waddr <= last_idx)

endmodule

// ===== src/bspline_point_evaluator_core.sv =====
// B-spline point evaluator: a write beat is stored on accept. An evaluate beat fills level
// one with span indicators, then per level k>=2 reads each entry with its neighbour,
// divides its nonzero terms on the serial divider, writes it back, then weights and sums
// the n points and hands off; the result beat shows the cycle after. One item in work at
// a time: the next beat is accepted the cycle after hand-off, output stalls hold hand-off.
// Reset (synchronous, high): order 3, count 2, idle, no result pending; no store clearing.
module bspline_point_evaluator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bpe_pkg::bpe_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bpe_pkg::bpe_rsp_type            rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bpe_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [bpe_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [bpe_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);

   // Configuration registers.
   logic [bpe_pkg::ORDER_W-1:0] order_ff, order_in;
   logic [bpe_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        csr_wr;
   logic [bpe_pkg::CSR_AW-3:0]  csr_idx;

   // Result register between the sequencer and the rsp channel.
   logic                 rsp_valid_ff, rsp_valid_in;
   bpe_pkg::bpe_rsp_type rsp_data_ff, rsp_data_in;

   logic                               res_valid, res_ready;
   bpe_pkg::bpe_rsp_type               res_data;
   bpe_pkg::bpe_cfg_type               cfg;
   bpe_pkg::bpe_mem_ctl_type           mem_ctl;
   bpe_pkg::bpe_point_type             pt_rdata;
   logic signed [bpe_pkg::BASIS_W-1:0] bs_rdata;
   bpe_pkg::bpe_div_req_type           div_req;
   bpe_pkg::bpe_div_rsp_type           div_rsp;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[bpe_pkg::CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode register writes; reads return the stored value zero-extended.
   always_comb begin
      order_in = order_ff;
      count_in = count_ff;
      if (csr_wr) begin
         case (csr_idx)
            bpe_pkg::REG_ORDER: order_in = csr_pwdata[bpe_pkg::ORDER_W-1:0];
            bpe_pkg::REG_COUNT: count_in = csr_pwdata[bpe_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
      case (csr_idx)
         bpe_pkg::REG_ORDER: csr_prdata = bpe_pkg::CSR_DW'(order_ff);
         bpe_pkg::REG_COUNT: csr_prdata = bpe_pkg::CSR_DW'(count_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= bpe_pkg::ORDER_W'(3);
         count_ff <= bpe_pkg::COUNT_W'(2);
      end else begin
         order_ff <= order_in;
         count_ff <= count_in;
      end
   end

   assign cfg.order = order_ff;
   assign cfg.count = count_ff;

   // Take a new result when the register is empty or its beat leaves now.
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: knot spans, in-place basis update, weighted sum.
   bpe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .mem_ctl   (mem_ctl),
      .pt_rdata  (pt_rdata),
      .bs_rdata  (bs_rdata),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   // Point store and basis scratch, registered reads.
   bpe_mem u_mem (
      .clock    (clock),
      .ctl      (mem_ctl),
      .pt_rdata (pt_rdata),
      .bs_rdata (bs_rdata)
   );

   // Shared serial divider for the basis terms.
   bpe_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for bspline_point_evaluator_core.
// Depends on bpe_pkg and the core RTL. A queue-fed driver, an in-bench curve
// predictor and a monitor that compares every result beat.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 10000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bpe_pkg::bpe_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bpe_pkg::bpe_rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [bpe_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [bpe_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [bpe_pkg::CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   bspline_point_evaluator_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Bench copy of configuration and point store
   logic [bpe_pkg::ORDER_W-1:0] cur_order = 4'd3;
   logic [bpe_pkg::COUNT_W-1:0] cur_count = 7'd2;
   logic signed [bpe_pkg::COORD_W-1:0] pts_x [bpe_pkg::MAX_POINTS];
   logic signed [bpe_pkg::COORD_W-1:0] pts_y [bpe_pkg::MAX_POINTS];
   logic signed [bpe_pkg::COORD_W-1:0] pts_z [bpe_pkg::MAX_POINTS];
   bit slot_written [bpe_pkg::MAX_POINTS];

   bpe_pkg::bpe_req_type pending_beats[$];
   bpe_pkg::bpe_rsp_type expected_points[$];
   int errors = 0;
   int evals_done = 0;
   int writes_done = 0;
   int cycles = 0;

   function automatic logic signed [bpe_pkg::COORD_W-1:0] sat32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // Cox-de Boor with integer knots, Q.16 basis, truncating divisions
   function automatic bpe_pkg::bpe_rsp_type eval_curve(
      input logic [bpe_pkg::PARAM_W-1:0] param);
      longint knot [bpe_pkg::KNOT_LEN];
      longint basis [bpe_pkg::KNOT_LEN];
      longint r, n, tq, lo, hi, lft, rgt, num, d, ax, ay, az, s;
      bit closed, in_span;
      bpe_pkg::bpe_rsp_type res;
      r = cur_order;
      if (r < 1) r = 1;
      if (r > bpe_pkg::MAX_ORDER) r = bpe_pkg::MAX_ORDER;
      n = cur_count;
      if (n < 2) n = 2;
      if (n > bpe_pkg::MAX_POINTS) n = bpe_pkg::MAX_POINTS;
      tq = (param > bpe_pkg::ONE_Q16) ? bpe_pkg::ONE_Q16 : param;
      tq = tq * (n - 1);
      closed = tq >= (n - 1) * bpe_pkg::ONE_Q16;
      for (int i = 0; i < r + n + 1; i++)
         knot[i] = (i < r) ? 0 : ((i < n) ? i - r + 1 : n - r + 2);
      for (int i = 0; i <= n + r - 1; i++) begin
         lo = knot[i] * bpe_pkg::ONE_Q16;
         hi = knot[i + 1] * bpe_pkg::ONE_Q16;
         in_span = tq >= lo && (closed ? tq <= hi : tq < hi);
         basis[i] = in_span ? bpe_pkg::ONE_Q16 : 0;
      end
      for (int k = 2; k <= r; k++) begin
         for (int i = 0; i <= n + r - k; i++) begin
            lo = knot[i] * bpe_pkg::ONE_Q16;
            hi = knot[i + k] * bpe_pkg::ONE_Q16;
            in_span = tq >= lo && (closed ? tq <= hi : tq < hi);
            if (!in_span) begin
               basis[i] = 0;
            end else begin
               lft = 0;
               rgt = 0;
               num = tq - lo;
               d = knot[i + k - 1] - knot[i];
               if (num != 0 && d != 0) lft = (num * basis[i]) / (d * bpe_pkg::ONE_Q16);
               num = hi - tq;
               d = knot[i + k] - knot[i + 1];
               if (num != 0 && d != 0) rgt = (num * basis[i + 1]) / (d * bpe_pkg::ONE_Q16);
               s = lft + rgt;
               if (s > bpe_pkg::BASIS_LIM) s = bpe_pkg::BASIS_LIM;
               if (s < -bpe_pkg::BASIS_LIM) s = -bpe_pkg::BASIS_LIM;
               basis[i] = s;
            end
         end
      end
      ax = 0;
      ay = 0;
      az = 0;
      for (int i = 0; i < n; i++) begin
         ax += longint'(pts_x[i]) * basis[i];
         ay += longint'(pts_y[i]) * basis[i];
         az += longint'(pts_z[i]) * basis[i];
      end
      res.out_x = sat32(ax / bpe_pkg::ONE_Q16);
      res.out_y = sat32(ay / bpe_pkg::ONE_Q16);
      res.out_z = sat32(az / bpe_pkg::ONE_Q16);
      return res;
   endfunction

   // Driver: bursts of beats with random gaps; hold the payload while stalled
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.command == bpe_pkg::CMD_WRITE) begin
               pts_x[req_data.point_index] = req_data.coord_x;
               pts_y[req_data.point_index] = req_data.coord_y;
               pts_z[req_data.point_index] = req_data.coord_z;
               writes_done++;
            end else begin
               expected_points = {expected_points, eval_curve(req_data.curve_param)};
            end
            void'(pending_beats.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_beats[0];
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern: a randomly picked mode, mode 0 never stalls
   int stall_mode = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 32 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= (cycles % 5 < 2);
      endcase
   end

   // Monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("result beat with no prediction pending");
            errors++;
         end else begin
            bpe_pkg::bpe_rsp_type exp_pt;
            exp_pt = expected_points.pop_front();
            evals_done++;
            if (rsp_data.out_x !== exp_pt.out_x) begin
               $error("out_x expected %0d got %0d", exp_pt.out_x, rsp_data.out_x);
               errors++;
            end
            if (rsp_data.out_y !== exp_pt.out_y) begin
               $error("out_y expected %0d got %0d", exp_pt.out_y, rsp_data.out_y);
               errors++;
            end
            if (rsp_data.out_z !== exp_pt.out_z) begin
               $error("out_z expected %0d got %0d", exp_pt.out_z, rsp_data.out_z);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL bspline_point_evaluator_core");
         $finish;
      end
   end

   task automatic csr_write(input int idx, input logic [bpe_pkg::CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= bpe_pkg::CSR_AW'(idx * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == int'(bpe_pkg::REG_ORDER)) cur_order = value[bpe_pkg::ORDER_W-1:0];
      else cur_count = value[bpe_pkg::COUNT_W-1:0];
   endtask

   function automatic logic [bpe_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_write(input int slot);
      bpe_pkg::bpe_req_type b;
      b.command = bpe_pkg::CMD_WRITE;
      b.point_index = bpe_pkg::INDEX_W'(slot);
      b.coord_x = rand_coord();
      b.coord_y = rand_coord();
      b.coord_z = rand_coord();
      b.curve_param = bpe_pkg::PARAM_W'($urandom);
      slot_written[slot] = 1'b1;
      pending_beats = {pending_beats, b};
   endtask

   // Queue an evaluate; first fill any slot in use that was never written
   task automatic queue_eval(input logic [bpe_pkg::PARAM_W-1:0] param);
      bpe_pkg::bpe_req_type b;
      int n;
      n = cur_count < 2 ? 2 : (cur_count > bpe_pkg::MAX_POINTS ? bpe_pkg::MAX_POINTS
                                                               : cur_count);
      for (int i = 0; i < n; i++)
         if (!slot_written[i]) queue_write(i);
      b.command = bpe_pkg::CMD_EVAL;
      b.point_index = bpe_pkg::INDEX_W'($urandom);
      b.coord_x = $urandom;
      b.coord_y = $urandom;
      b.coord_z = $urandom;
      b.curve_param = param;
      pending_beats = {pending_beats, b};
   endtask

   function automatic logic [bpe_pkg::PARAM_W-1:0] rand_param();
      int n;
      n = cur_count < 2 ? 2 : (cur_count > bpe_pkg::MAX_POINTS ? bpe_pkg::MAX_POINTS
                                                               : cur_count);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return bpe_pkg::PARAM_W'(bpe_pkg::ONE_Q16);
         2: return bpe_pkg::PARAM_W'($urandom_range(bpe_pkg::ONE_Q16 + 1,
                                                    2 * bpe_pkg::ONE_Q16 - 1));
         3: return bpe_pkg::PARAM_W'(($urandom_range(0, n - 1) * bpe_pkg::ONE_Q16)
                                     / (n - 1));
         default: return bpe_pkg::PARAM_W'($urandom_range(0, bpe_pkg::ONE_Q16));
      endcase
   endfunction

   // Wait for an idle block before touching the registers
   task automatic drain();
      while (pending_beats.size() != 0 || expected_points.size() != 0 || req_valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int orders[14] = '{3, 1, 8, 0, 15, 2, 8, 5, 4, 6, 9, 2, 7, 3};
      int counts[14] = '{2, 2, 64, 5, 3, 0, 2, 127, 1, 8, 6, 4, 9, 65};
      int items;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 14; p++) begin
         drain();
         csr_write(int'(bpe_pkg::REG_ORDER), orders[p]);
         csr_write(int'(bpe_pkg::REG_COUNT), counts[p]);
         // Directed corners: both ends of t, t beyond one, extreme points
         if (p == 0) begin
            queue_write(0);
            queue_write(1);
            queue_write(63);
         end
         queue_eval('0);
         queue_eval(bpe_pkg::PARAM_W'(bpe_pkg::ONE_Q16));
         queue_eval(bpe_pkg::PARAM_W'(2 * bpe_pkg::ONE_Q16 - 1));
         queue_eval(bpe_pkg::PARAM_W'(1));
         queue_eval(bpe_pkg::PARAM_W'(bpe_pkg::ONE_Q16 - 1));
         items = (counts[p] > 16) ? 12 : 95;
         for (int j = 0; j < items; j++) begin
            if ($urandom_range(0, 9) < 3) queue_write($urandom_range(0, bpe_pkg::MAX_POINTS - 1));
            else queue_eval(rand_param());
         end
      end
      drain();
      repeat (200) @(posedge clock);
      $display("Covered %0d evaluations and %0d point writes over 14 register settings.",
               evals_done, writes_done);
      $display("Orders from 0 to 15 and counts from 0 to 127, out-of-range values included.");
      if (errors == 0 && expected_points.size() == 0) begin
         $display("PASS bspline_point_evaluator_core");
      end else begin
         $display("FAIL bspline_point_evaluator_core");
      end
      $finish;
   end

endmodule
